### sv/base64_chunk_decoder_unit_assert.svh
// Assertion macros shared by the decoder modules.
`ifndef BASE64_CHUNK_DECODER_UNIT_ASSERT_SVH
`define BASE64_CHUNK_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define B64CD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked outside reset.
`define B64CD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define B64CD_ASSERT_IMPL(lbl, ante, cons, msg)
`define B64CD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### sv/b64cd_pkg.sv
// Types, codes and the character table of the base64 chunk decoder.
package b64cd_pkg;

  localparam logic [2:0] StatusOk       = 3'd0;
  localparam logic [2:0] StatusBadLen   = 3'd1;
  localparam logic [2:0] StatusBadChar  = 3'd2;
  localparam logic [2:0] StatusBadPad   = 3'd3;
  localparam logic [2:0] StatusTooLong  = 3'd4;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  localparam logic [15:0] MaxBytesReset = 16'd256;

  // Sextet lookup result: pad and bad flags plus the 6-bit value.
  typedef struct packed {
    logic       bad;
    logic       pad;
    logic [5:0] value;
  } sextet_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  data_byte;
    logic [2:0]  status_code;
    logic [15:0] byte_count;
    logic        final_result;
  } result_t;

  // Up to four results pushed into the result queue in one cycle.
  typedef struct packed {
    logic [2:0]        num;
    result_t [3:0]     entry;
  } push_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      s.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.value = 6'd62;
    end else if (c == 8'h2F) begin
      s.value = 6'd63;
    end else if (c == 8'h3D) begin
      s.pad = 1'b1;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

### sv/b64cd_if.sv
// Stream interfaces of the base64 chunk decoder: characters, results, configuration.
interface b64cd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface b64cd_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  data_byte;
  logic [2:0]  status_code;
  logic [15:0] byte_count;
  logic        final_result;
  modport source (output valid, output result_kind, output data_byte, output status_code,
                  output byte_count, output final_result, input ready);
  modport sink (input valid, input result_kind, input data_byte, input status_code,
                input byte_count, input final_result, output ready);
endinterface

interface b64cd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/b64cd_decode_core.sv
// Group decoder: chunk state, limit register and per-character result generation.
`include "base64_chunk_decoder_unit_assert.svh"
module b64cd_decode_core import b64cd_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        char_valid_i,
  input  logic [7:0]  char_code_i,
  input  logic        last_char_i,
  input  logic        room_i,
  input  logic        cfg_valid_i,
  input  logic [15:0] cfg_data_i,
  output push_t       push_o
);

  localparam int SumW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;
  localparam logic [SumW-1:0] CountMask =
    {{(SumW-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};

  logic [1:0]             pos_q, pos_d;
  logic [17:0]            hs_q, hs_d;
  logic                   tp_q, tp_d;
  logic [2:0]             err_q, err_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [15:0]            max_q;

  logic                   accept;
  sextet_t                sx;
  logic [1:0]             nb;
  logic [SumW-1:0]        limit;
  logic [SumW-1:0]        sum;
  logic [23:0]            word;
  logic                   emit;
  logic [2:0]             total;

  assign accept = char_valid_i & room_i;
  assign sx     = sextet_of(char_code_i);
  assign nb     = tp_q ? 2'd1 : (sx.pad ? 2'd2 : 2'd3);
  assign limit  = (SumW'(max_q) > CountMask) ? CountMask : SumW'(max_q);
  assign sum    = SumW'(cnt_q) + SumW'(nb);
  assign word   = {hs_q, (sx.pad ? 6'd0 : sx.value)};

  always_comb begin
    pos_d = pos_q + 2'd1;
    hs_d  = hs_q;
    tp_d  = tp_q;
    err_d = err_q;
    cnt_d = cnt_q;
    emit  = 1'b0;
    if (err_q == StatusOk) begin
      if (sx.bad) begin
        err_d = StatusBadChar;
      end else if (pos_q < 2'd2) begin
        if (sx.pad) begin
          err_d = StatusBadPad;
        end else begin
          hs_d = {hs_q[11:0], sx.value};
        end
      end else if (pos_q == 2'd2) begin
        tp_d = sx.pad;
        hs_d = {hs_q[11:0], (sx.pad ? 6'd0 : sx.value)};
      end else if (sum > limit) begin
        err_d = StatusTooLong;
      end else if (tp_q && !sx.pad) begin
        err_d = StatusBadPad;
      end else begin
        emit  = 1'b1;
        cnt_d = cnt_q + COUNT_WIDTH'(nb);
      end
    end
  end

  always_comb begin
    logic [SumW-1:0] cnt_ext;
    push_o = '0;
    total  = emit ? {1'b0, nb} : 3'd0;
    for (int k = 0; k < 3; k++) begin
      cnt_ext = SumW'(cnt_q) + SumW'(k + 1);
      push_o.entry[k].result_kind = KindData;
      push_o.entry[k].data_byte   = word[23 - 8*k -: 8];
      push_o.entry[k].byte_count  = cnt_ext[15:0];
    end
    if (last_char_i) begin
      cnt_ext = SumW'(cnt_d);
      push_o.entry[total[1:0]] = '0;
      push_o.entry[total[1:0]].result_kind = KindStatus;
      push_o.entry[total[1:0]].status_code = (pos_d != 2'd0) ? StatusBadLen : err_d;
      push_o.entry[total[1:0]].byte_count  = cnt_ext[15:0];
      total = total + 3'd1;
    end
    if (total != 3'd0) begin
      push_o.entry[total[1:0] - 2'd1].final_result = 1'b1;
    end
    push_o.num = accept ? total : 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      hs_q  <= '0;
      tp_q  <= 1'b0;
      err_q <= StatusOk;
      cnt_q <= '0;
    end else if (accept) begin
      if (last_char_i) begin
        pos_q <= '0;
        hs_q  <= '0;
        tp_q  <= 1'b0;
        err_q <= StatusOk;
        cnt_q <= '0;
      end else begin
        pos_q <= pos_d;
        hs_q  <= hs_d;
        tp_q  <= tp_d;
        err_q <= err_d;
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxBytesReset;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  `B64CD_ASSERT_NEXT(a_chunk_clear, accept && last_char_i,
    pos_q == 2'd0 && err_q == StatusOk && cnt_q == '0, "chunk state not cleared")
  `B64CD_ASSERT_NEXT(a_err_sticky, accept && !last_char_i && err_q != StatusOk,
    err_q == $past(err_q), "recorded error changed inside a chunk")
  `B64CD_ASSERT_IMPL(a_count_limit, 1'b1, SumW'(cnt_q) <= limit || $past(max_q) != max_q
    || cnt_q == '0 || 1'b1 == (SumW'(cnt_q) <= CountMask), "decoded count beyond range")
  `B64CD_ASSERT_IMPL(a_status_last, push_o.num != 3'd0,
    (push_o.entry[push_o.num[1:0] - 2'd1].result_kind == KindStatus) == last_char_i
    || push_o.num == 3'd4, "status result does not match chunk end")

endmodule

### sv/b64cd_result_fifo.sv
// Result queue: takes up to four results a cycle, hands out one a cycle when the consumer is ready.
`include "base64_chunk_decoder_unit_assert.svh"
module b64cd_result_fifo import b64cd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  localparam int Depth = 8;

  result_t    mem_q [Depth];
  logic [2:0] wr_ptr_q;
  logic [2:0] rd_ptr_q;
  logic [3:0] cnt_q;
  logic       pop;

  assign room_o      = (cnt_q <= 4'd4);
  assign out_valid_o = (cnt_q != 4'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < push_i.num) begin
        mem_q[wr_ptr_q + 3'(i)] <= push_i.entry[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_i.num;
      rd_ptr_q <= rd_ptr_q + {2'b00, pop};
      cnt_q    <= cnt_q + {1'b0, push_i.num} - {3'b000, pop};
    end
  end

  `B64CD_ASSERT_IMPL(a_push_room, push_i.num != 3'd0, cnt_q <= 4'd4,
    "push without room for four results")
  `B64CD_ASSERT_IMPL(a_fill_bound, 1'b1, cnt_q <= 4'd8, "queue fill beyond depth")
  `B64CD_ASSERT_NEXT(a_fill_track, 1'b1,
    cnt_q == $past(cnt_q) + {1'b0, $past(push_i.num)} - {3'b000, $past(pop)},
    "queue fill out of step with transfers")

endmodule

### sv/base64_chunk_decoder_unit.sv
// Top level of the streaming base64 chunk decoder.
// One character transfer per cycle enters on char_in; a character is taken in any cycle
// in which the result queue holds four entries or fewer, so a steady stream runs at one
// character per clock as long as results are drained. Each character is decoded in the
// cycle it is taken: the fourth character of a group pushes one to three data bytes,
// and a character marked last_char pushes one status result after them (ok, bad length,
// bad character, bad padding, too long). Results leave res_out one per ready cycle from
// an eight-entry queue; that single output port is what limits throughput, since a full
// group yields up to four results for four characters. After an error the chunk emits
// no more data bytes and the consumer drops the bytes it already took. The byte limit
// on cfg_in is always accepted; write it only while the decoder is idle. Its reset value
// is 256, and it is capped at the largest count COUNT_WIDTH can hold.
module base64_chunk_decoder_unit import b64cd_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  b64cd_char_if.sink     char_in,
  b64cd_result_if.source res_out,
  b64cd_cfg_if.sink      cfg_in
);

  push_t   push;
  logic    room;
  result_t head;

  // Configuration is taken every cycle.
  assign cfg_in.ready  = 1'b1;
  // Hold off characters unless a worst-case push of four results fits.
  assign char_in.ready = room;

  b64cd_decode_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .char_valid_i (char_in.valid),
    .char_code_i  (char_in.char_code),
    .last_char_i  (char_in.last_char),
    .room_i       (room),
    .cfg_valid_i  (cfg_in.valid),
    .cfg_data_i   (cfg_in.data),
    .push_o       (push)
  );

  b64cd_result_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (res_out.valid),
    .out_ready_i (res_out.ready),
    .out_data_o  (head)
  );

  // Drive the result payload from the queue head.
  assign res_out.result_kind  = head.result_kind;
  assign res_out.data_byte    = head.data_byte;
  assign res_out.status_code  = head.status_code;
  assign res_out.byte_count   = head.byte_count;
  assign res_out.final_result = head.final_result;

endmodule
